@@ hw/rtl/pal_pkg.sv @@
// Shared constants, codes and item types for the positional array list.
package pal_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 7;
  localparam int unsigned FIDX_W   = 6;
  localparam int unsigned ECNT_W   = 7;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  item_value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic [FIDX_W-1:0]         found_index;
    logic [ECNT_W-1:0]         entry_count;
    logic                      is_empty;
  } out_item_t;

endpackage

@@ hw/rtl/positional_array_list.sv @@
// Ordered list of signed 32-bit values with insert, erase, find and modify.
// Modify and rejected items need no shift or search; insert moves entries from the
// position up, erase moves those above it down, find reads from 0 to a match or the end.
// One item is worked on at a time; the next item is taken the cycle after a result
// enters the output register. Each shift or search step is one read of the store.
// Reset clears the state, count, step count and valid flags; the store is not cleared.
module positional_array_list (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pal_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pal_pkg::out_item_t   out_item_o
);

  localparam int unsigned IW = pal_pkg::IDX_W;
  localparam int unsigned CW = pal_pkg::CNT_W;
  localparam int unsigned FW = pal_pkg::FIDX_W;
  localparam int unsigned EW = pal_pkg::ECNT_W;
  localparam int unsigned DW = pal_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       rem_q, rem_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic [DW-1:0]       val_q, val_d;
  pal_pkg::cmd_e       cmd_q, cmd_d;
  pal_pkg::status_e    stat_q, stat_d;
  logic [IW-1:0]       fidx_q, fidx_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IW-1:0]       rd_tag_q, rd_tag_d;
  logic [DW-1:0]       rdata_q;
  logic                out_valid_q, out_valid_d;
  pal_pkg::out_item_t  out_item_q, out_item_d;

  logic [DW-1:0]       store_q [pal_pkg::CAPACITY];

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [DW-1:0]       mem_wdata;
  logic [IW-1:0]       mem_raddr;

  logic                in_acc, out_free, match, issue, finish;
  logic [31:0]         pos_w, cnt_w;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign match       = (state_q == S_BUSY) && (cmd_q == pal_pkg::CMD_FIND) && rd_vld_q &&
                       (rdata_q == val_q);
  assign issue       = (state_q == S_BUSY) && (rem_q != '0) && !match;
  assign finish      = (state_q == S_BUSY) && (rem_q == '0) && !rd_vld_q && out_free;
  assign pos_w       = 32'(in_item_i.position);
  assign cnt_w       = 32'(cnt_q);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    val_d       = val_q;
    cmd_d       = cmd_q;
    stat_d      = stat_q;
    fidx_d      = fidx_q;
    rd_vld_d    = issue;
    rd_tag_d    = idx_q;
    mem_raddr   = idx_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    if (in_acc) begin
      state_d = S_BUSY;
      cmd_d   = in_item_i.cmd;
      pos_d   = IW'(in_item_i.position);
      val_d   = $unsigned(in_item_i.item_value);
      stat_d  = pal_pkg::ST_OK;
      fidx_d  = '0;
      rem_d   = '0;
      idx_d   = '0;
      case (in_item_i.cmd)
        pal_pkg::CMD_INSERT: begin
          if (pos_w > cnt_w) begin
            stat_d = pal_pkg::ST_BAD_POS;
          end else if (cnt_w >= pal_pkg::CAPACITY) begin
            stat_d = pal_pkg::ST_FULL;
          end else begin
            rem_d = CW'(cnt_w - pos_w);
            idx_d = IW'(cnt_w - 32'd1);
          end
        end
        pal_pkg::CMD_ERASE: begin
          if (cnt_w == 32'd0) begin
            stat_d = pal_pkg::ST_EMPTY;
          end else if (pos_w >= cnt_w) begin
            stat_d = pal_pkg::ST_BAD_POS;
          end else begin
            rem_d = CW'(cnt_w - pos_w - 32'd1);
            idx_d = IW'(pos_w + 32'd1);
          end
        end
        pal_pkg::CMD_FIND: begin
          stat_d = pal_pkg::ST_NOT_FOUND;
          rem_d  = cnt_q;
        end
        pal_pkg::CMD_MODIFY: begin
          if (pos_w >= cnt_w) begin
            stat_d = pal_pkg::ST_BAD_POS;
          end
        end
        default: begin
          stat_d = pal_pkg::ST_BAD_POS;
        end
      endcase
    end

    if (issue) begin
      rem_d = rem_q - CW'(1);
      if (cmd_q == pal_pkg::CMD_INSERT) begin
        idx_d = idx_q - IW'(1);
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end

    if (rd_vld_q && (state_q == S_BUSY)) begin
      case (cmd_q)
        pal_pkg::CMD_INSERT: begin
          mem_we    = 1'b1;
          mem_waddr = rd_tag_q + IW'(1);
          mem_wdata = rdata_q;
        end
        pal_pkg::CMD_ERASE: begin
          mem_we    = 1'b1;
          mem_waddr = rd_tag_q - IW'(1);
          mem_wdata = rdata_q;
        end
        pal_pkg::CMD_FIND: begin
          if (match) begin
            stat_d = pal_pkg::ST_OK;
            fidx_d = rd_tag_q;
            rem_d  = '0;
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end

    if (finish) begin
      state_d = S_IDLE;
      if (stat_q == pal_pkg::ST_OK) begin
        case (cmd_q)
          pal_pkg::CMD_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_q;
            mem_wdata = val_q;
            cnt_d     = cnt_q + CW'(1);
          end
          pal_pkg::CMD_ERASE: begin
            cnt_d = cnt_q - CW'(1);
          end
          pal_pkg::CMD_MODIFY: begin
            mem_we    = 1'b1;
            mem_waddr = pos_q;
            mem_wdata = val_q;
          end
          default: begin
            cnt_d = cnt_q;
          end
        endcase
      end
      out_valid_d            = 1'b1;
      out_item_d.status      = stat_q;
      out_item_d.found_index = FW'(fidx_q);
      out_item_d.entry_count = EW'(cnt_d);
      out_item_d.is_empty    = (cnt_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    cmd_q      <= cmd_d;
    stat_q     <= stat_d;
    fidx_q     <= fidx_d;
    rd_tag_q   <= rd_tag_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_q[mem_raddr];
  end

endmodule

@@ hw/rtl/pal_checker.sv @@
// Port-level checks for the positional array list and their binding.
module pal_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pal_pkg::out_item_t  out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result item changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block took no time to work on an accepted item.");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.is_empty == (out_item_o.entry_count == '0))
    else $error("Empty flag disagrees with the entry count.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_item_o.entry_count) <= pal_pkg::CAPACITY)
    else $error("Entry count exceeds the capacity.");

  a_index_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.found_index != '0) |-> out_item_o.status == pal_pkg::ST_OK)
    else $error("Found index is set on a result that is not ok.");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
